[rtl/tvhg_pkg.sv]
// Shared types and constants for the tetrahedron volume / hat gradient block.
// No dependencies.
`default_nettype none
package tvhg_pkg;

  localparam int CW   = 16;  // vertex coordinate width
  localparam int DW   = 17;  // vertex difference width
  localparam int PW   = 34;  // difference product width
  localparam int GW   = 36;  // cross product component width
  localparam int MW   = 54;  // |det| width
  localparam int SH   = 30;  // gradient scale shift
  localparam int NW   = GW + SH;  // divider dividend width
  localparam int OGW  = 48;  // gradient output width
  localparam int VOLW = 51;  // volume output width
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [1:0] PAIR_TBL [4][4] = '{
    '{2'd1, 2'd2, 2'd3, 2'd1},
    '{2'd3, 2'd2, 2'd0, 2'd2},
    '{2'd3, 2'd0, 2'd1, 2'd3},
    '{2'd1, 2'd0, 2'd2, 2'd0}
  };

  typedef struct packed {
    logic [3:0][2:0][GW-1:0] g;
    logic [MW-1:0]           mag;
    logic [2:0][CW-1:0]      bary;
    logic                    degen;
  } qent_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } bstate_t;

endpackage
`default_nettype wire

[rtl/tetra_volume_hat_gradient.sv]
// Top level: P1 tetrahedron volume, barycenter and hat-function gradients.
// Depends on tvhg_pkg, tvhg_front, tvhg_queue, tvhg_back.
//
// Input: one tetrahedron per word on in_* (twelve Q2.14 coordinates).
// Output: four words per tetrahedron, rows 0..3 in order, tlast on row 3.
// Each row carries its gradient (Q32.16, saturated), volume (2^-42 units),
// barycenter and the degenerate flag (zero volume forces zero gradients).
// A four-stage front pipeline takes a word every cycle while the queue has
// room; the back end divides each row with bit-serial restoring dividers,
// one quotient bit per cycle over 66 bits, one row at a time, with an idle
// state before the first row of each tetrahedron. The volume divide
// by six runs in four digit steps under the first gradient steps.
// The dividers, reused for every row, set the throughput.
// Reset (rst_n low, synchronous) empties the pipeline and queue.
// A stall on out_tready holds the output word; the front keeps taking
// input until the queue fills, then drops in_tready.
`default_nettype none
module tetra_volume_hat_gradient #(
  parameter int QUEUE_DEPTH = tvhg_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, v3_x, v3_y, v3_z
  input  wire logic [191:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // grad_x, grad_y, grad_z, volume, bary_x, bary_y, bary_z, 5 bits zero
  output logic [247:0]      out_tdata,
  // vertex_index, degenerate
  output logic [2:0]        out_tuser,
  output logic              out_tlast
);

  tvhg_pkg::qent_t push_ent, head;
  logic push, q_full, nempty, pop;
  logic [1:0] idx;
  logic [2:0][tvhg_pkg::OGW-1:0] grad;
  logic [tvhg_pkg::VOLW-1:0] vol;
  logic [2:0][tvhg_pkg::CW-1:0] bary;
  logic degen;

  tvhg_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .in_data(in_tdata), .q_full(q_full), .push(push), .push_ent(push_ent)
  );

  tvhg_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_ent(push_ent), .full(q_full),
    .nempty(nempty), .pop(pop), .head(head)
  );

  tvhg_back u_back (
    .clk(clk), .rst_n(rst_n), .nempty(nempty), .head(head), .pop(pop),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_index(idx),
    .out_grad(grad), .out_vol(vol), .out_bary(bary), .out_degen(degen),
    .out_last(out_tlast)
  );

  assign out_tdata = {5'b0, bary[2], bary[1], bary[0], vol, grad[2], grad[1], grad[0]};
  assign out_tuser = {degen, idx};

endmodule
`default_nettype wire

[rtl/tvhg_front.sv]
// Front pipeline: vertex differences, cross products, determinant, barycenter.
// Depends on tvhg_pkg.
`default_nettype none
module tvhg_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [12*tvhg_pkg::CW-1:0] in_data,
  input  wire logic                q_full,
  output logic                     push,
  output tvhg_pkg::qent_t          push_ent
);

  localparam int CW = tvhg_pkg::CW;
  localparam int DW = tvhg_pkg::DW;
  localparam int PW = tvhg_pkg::PW;
  localparam int GW = tvhg_pkg::GW;
  localparam int MW = tvhg_pkg::MW;
  localparam int EW = DW + GW;

  logic en;
  logic v1_r, v2_r, v3_r, v4_r;

  logic signed [CW-1:0] n [4][3];
  logic signed [DW-1:0] u_nxt [4][3];
  logic signed [DW-1:0] w_nxt [4][3];
  logic signed [DW-1:0] e3_nxt [3];
  logic signed [CW-1:0] b_nxt [3];

  logic signed [DW-1:0] u1_r [4][3];
  logic signed [DW-1:0] w1_r [4][3];
  logic signed [DW-1:0] e3_1_r [3];
  logic signed [CW-1:0] b1_r [3];

  logic signed [PW-1:0] pr2_r [5][6];
  logic signed [DW-1:0] e1_2_r [3];
  logic signed [CW-1:0] b2_r [3];

  logic signed [GW-1:0] g3_r [5][3];
  logic signed [DW-1:0] e1_3_r [3];
  logic signed [CW-1:0] b3_r [3];

  logic signed [EW-1:0] dp4_r [3];
  logic signed [GW-1:0] g4_r [4][3];
  logic signed [CW-1:0] b4_r [3];

  logic signed [EW+1:0] det;

  function automatic logic [1:0] PAIR_TBL_IDX(input int k, input int p);
    return tvhg_pkg::PAIR_TBL[k][p];
  endfunction

  assign en       = !v4_r || !q_full;
  assign in_ready = en;
  assign push     = v4_r && !q_full;

  always_comb begin
    logic signed [CW+1:0] s;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 3; j++) begin
        n[i][j] = $signed(in_data[(i*3+j)*CW +: CW]);
      end
    end
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 3; j++) begin
        u_nxt[k][j] = DW'(n[PAIR_TBL_IDX(k, 0)][j]) - DW'(n[PAIR_TBL_IDX(k, 1)][j]);
        w_nxt[k][j] = DW'(n[PAIR_TBL_IDX(k, 2)][j]) - DW'(n[PAIR_TBL_IDX(k, 3)][j]);
      end
    end
    for (int j = 0; j < 3; j++) begin
      e3_nxt[j] = DW'(n[3][j]) - DW'(n[0][j]);
      s = (CW+2)'(n[0][j]) + (CW+2)'(n[1][j]) + (CW+2)'(n[2][j]) + (CW+2)'(n[3][j]);
      if (s < 0) begin
        s = s + (CW+2)'(3);
      end
      b_nxt[j] = CW'(s >>> 2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u1_r   <= u_nxt;
      w1_r   <= w_nxt;
      e3_1_r <= e3_nxt;
      b1_r   <= b_nxt;
      // rows 0..3 use their (u,v); entry 4 is e2 x e3
      for (int k = 0; k < 5; k++) begin
        logic signed [DW-1:0] a [3];
        logic signed [DW-1:0] b [3];
        for (int j = 0; j < 3; j++) begin
          a[j] = (k == 4) ? w1_r[3][j] : u1_r[k][j];
          b[j] = (k == 4) ? e3_1_r[j]  : w1_r[k][j];
        end
        pr2_r[k][0] <= a[1] * b[2];
        pr2_r[k][1] <= a[2] * b[1];
        pr2_r[k][2] <= a[2] * b[0];
        pr2_r[k][3] <= a[0] * b[2];
        pr2_r[k][4] <= a[0] * b[1];
        pr2_r[k][5] <= a[1] * b[0];
      end
      e1_2_r <= u1_r[3];
      b2_r   <= b1_r;
      for (int k = 0; k < 5; k++) begin
        for (int j = 0; j < 3; j++) begin
          g3_r[k][j] <= GW'(pr2_r[k][2*j]) - GW'(pr2_r[k][2*j+1]);
        end
      end
      e1_3_r <= e1_2_r;
      b3_r   <= b2_r;
      for (int j = 0; j < 3; j++) begin
        dp4_r[j] <= EW'(e1_3_r[j]) * EW'(g3_r[4][j]);
      end
      for (int k = 0; k < 4; k++) begin
        g4_r[k] <= g3_r[k];
      end
      b4_r <= b3_r;
    end
  end

  assign det = (EW+2)'(dp4_r[0]) + (EW+2)'(dp4_r[1]) + (EW+2)'(dp4_r[2]);

  always_comb begin
    logic [EW+1:0] mag_w;
    mag_w = det[EW+1] ? (EW+2)'(-det) : det;
    push_ent.mag   = mag_w[MW-1:0];
    push_ent.degen = (det == '0);
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 3; j++) begin
        push_ent.g[k][j] = g4_r[k][j];
      end
    end
    for (int j = 0; j < 3; j++) begin
      push_ent.bary[j] = b4_r[j];
    end
  end

endmodule
`default_nettype wire

[rtl/tvhg_queue.sv]
// Small FIFO between the front pipeline and the divider back end.
// Depends on tvhg_pkg.
`default_nettype none
module tvhg_queue #(
  parameter int DEPTH = tvhg_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire tvhg_pkg::qent_t push_ent,
  output logic                 full,
  output logic                 nempty,
  input  wire logic            pop,
  output tvhg_pkg::qent_t      head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  tvhg_pkg::qent_t mem [DEPTH];
  logic [AW-1:0]   wp_r, rp_r;
  logic [CNTW-1:0] cnt_r;

  assign full   = (cnt_r == CNTW'(DEPTH));
  assign nempty = (cnt_r != '0);
  assign head   = mem[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
      end
      if (pop) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNTW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= push_ent;
    end
  end

endmodule
`default_nettype wire

[rtl/tvhg_back.sv]
// Back end: bit-serial dividers for the gradients, a digit-wise divide by six
// (reciprocal multiply per 14-bit digit) for the volume, output register.
// Depends on tvhg_pkg.
`default_nettype none
module tvhg_back (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   nempty,
  input  wire tvhg_pkg::qent_t        head,
  output logic                        pop,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [1:0]                  out_index,
  output logic [2:0][tvhg_pkg::OGW-1:0] out_grad,
  output logic [tvhg_pkg::VOLW-1:0]   out_vol,
  output logic [2:0][tvhg_pkg::CW-1:0] out_bary,
  output logic                        out_degen,
  output logic                        out_last
);

  localparam int GW  = tvhg_pkg::GW;
  localparam int MW  = tvhg_pkg::MW;
  localparam int NW  = tvhg_pkg::NW;
  localparam int SH  = tvhg_pkg::SH;
  localparam int OGW = tvhg_pkg::OGW;
  localparam int VOLW = tvhg_pkg::VOLW;
  localparam int STW = $clog2(NW);
  localparam int VCW  = 14;          // volume digit width
  localparam int VDIG = 4;           // volume digits
  localparam int VNW  = VDIG * VCW;  // volume dividend width
  localparam logic [VCW+1:0] RECIP3 = 16'd43691;  // (2^17 + 1) / 3

  tvhg_pkg::bstate_t state_r, state_nxt;
  logic [1:0]     row_r;
  logic [STW-1:0] step_r;
  logic [2:0][NW-1:0] a_r, q_r;
  logic [2:0][MW:0]   rem_r;
  logic [2:0]         neg_r;
  logic [VNW-1:0]     vd_r, vq_r;
  logic [1:0]         vrem_r;
  logic               out_valid_r;
  logic               slot_free, load, emit, step;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tvhg_pkg::ST_IDLE: if (nempty) state_nxt = tvhg_pkg::ST_DIV;
      tvhg_pkg::ST_DIV:  if (step_r == STW'(NW - 1)) state_nxt = tvhg_pkg::ST_DONE;
      tvhg_pkg::ST_DONE: begin
        if (slot_free) begin
          state_nxt = (row_r == 2'd3) ? tvhg_pkg::ST_IDLE : tvhg_pkg::ST_DIV;
        end
      end
      default: state_nxt = tvhg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    load = 1'b0;
    emit = 1'b0;
    pop  = 1'b0;
    step = 1'b0;
    unique case (state_r)
      tvhg_pkg::ST_IDLE: load = nempty;
      tvhg_pkg::ST_DIV:  step = 1'b1;
      tvhg_pkg::ST_DONE: begin
        emit = slot_free;
        pop  = slot_free && (row_r == 2'd3);
        load = slot_free && (row_r != 2'd3);
      end
      default: ;
    endcase
  end

  function automatic logic [OGW-1:0] sat(input logic [NW-1:0] q, input logic neg);
    logic [OGW-1:0] r;
    if (neg) begin
      if ((|q[NW-1:OGW]) || (q[OGW-1] && (|q[OGW-2:0]))) r = {1'b1, {(OGW-1){1'b0}}};
      else r = OGW'(-q[OGW-1:0]);
    end else begin
      if (|q[NW-1:OGW-1]) r = {1'b0, {(OGW-1){1'b1}}};
      else r = q[OGW-1:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tvhg_pkg::ST_IDLE;
      row_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) step_r <= '0;
      else if (step) step_r <= step_r + STW'(1);
      if (emit) row_r <= row_r + 2'd1;
      if (emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // ld_row is the row about to be divided
  always_ff @(posedge clk) begin
    logic [1:0] ld_row;
    logic signed [GW-1:0] c;
    logic [MW:0] rs;
    logic [VCW+1:0] vs, vt;
    logic [2*VCW+3:0] vp;
    logic [VCW-1:0] vdig;
    ld_row = (state_r == tvhg_pkg::ST_IDLE) ? 2'd0 : row_r + 2'd1;
    if (load) begin
      for (int j = 0; j < 3; j++) begin
        c = $signed(head.g[ld_row][j]);
        neg_r[j] <= c[GW-1];
        a_r[j]   <= {(c[GW-1] ? GW'(-c) : GW'(c)), {SH{1'b0}}};
        rem_r[j] <= '0;
        q_r[j]   <= '0;
      end
      // |D| / 6 = (|D| / 2) / 3
      vd_r   <= VNW'(head.mag[MW-1:1]);
      vrem_r <= '0;
      vq_r   <= '0;
    end else if (step) begin
      for (int j = 0; j < 3; j++) begin
        rs = {rem_r[j][MW-1:0], a_r[j][NW-1]};
        a_r[j] <= {a_r[j][NW-2:0], 1'b0};
        if (rs >= {1'b0, head.mag}) begin
          rem_r[j] <= rs - {1'b0, head.mag};
          q_r[j]   <= {q_r[j][NW-2:0], 1'b1};
        end else begin
          rem_r[j] <= rs;
          q_r[j]   <= {q_r[j][NW-2:0], 1'b0};
        end
      end
      if (step_r < STW'(VDIG)) begin
        vs   = {vrem_r, vd_r[VNW-1 -: VCW]};
        vp   = vs * RECIP3;
        vdig = vp[2*VCW+2 -: VCW];
        vt   = vs - {1'b0, vdig, 1'b0} - {2'b0, vdig};
        vrem_r <= vt[1:0];
        vd_r   <= {vd_r[VNW-VCW-1:0], {VCW{1'b0}}};
        vq_r   <= {vq_r[VNW-VCW-1:0], vdig};
      end
    end
    if (emit) begin
      out_index <= row_r;
      for (int j = 0; j < 3; j++) begin
        out_grad[j] <= head.degen ? '0 : sat(q_r[j], neg_r[j]);
      end
      out_vol   <= vq_r[VOLW-1:0];
      out_bary  <= head.bary;
      out_degen <= head.degen;
      out_last  <= (row_r == 2'd3);
    end
  end

  assign out_valid = out_valid_r;

  a_pop_row3: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (row_r == 2'd3) && nempty)
    else $error("pop before last row");
  a_step_rng: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tvhg_pkg::ST_DIV) |-> (step_r <= STW'(NW - 1)))
    else $error("divider step overrun");
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    $past(emit) && out_degen |-> (out_grad == '0))
    else $error("degenerate row with nonzero gradient");
  a_last_pop: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (row_r == 2'd0))
    else $error("row counter not wrapped after pop");

endmodule
`default_nettype wire

[test/tetra_volume_hat_gradient_tb.sv]
// Testbench for tetra_volume_hat_gradient: drives tetrahedra, predicts the four
// gradient rows of each in SystemVerilog and checks every output word field by field.
// Depends on tvhg_pkg and the RTL of the block.
`default_nettype none
module tetra_volume_hat_gradient_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  vidx;
    logic [47:0] gx, gy, gz;
    logic [50:0] vol;
    logic [15:0] bx, by, bz;
    logic        degen, last;
  } row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [191:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [247:0] out_tdata;
  logic [2:0]   out_tuser;
  logic         out_tlast;

  logic [191:0] tet_q[$];
  row_t         row_q[$];
  int           errors = 0;
  int           in_gap = 0;
  int           out_gap = 0;
  int           hold_off = 0;
  bit           stim_done = 1'b0;
  int           rows_seen = 0;

  tetra_volume_hat_gradient u_top (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic longint crd(logic [191:0] d, int i);
    return longint'($signed(d[i*16 +: 16]));
  endfunction

  function automatic logic [47:0] scaled_quot(longint c, longint mag);
    longint a, q;
    a = c < 0 ? -c : c;
    q = (a <<< 30) / mag;
    if (c < 0) begin
      if (q > 64'sh800000000000) q = 64'sh800000000000;
      return 48'(-q);
    end
    if (q > 64'sh7FFFFFFFFFFF) q = 64'sh7FFFFFFFFFFF;
    return 48'(q);
  endfunction

  task automatic predict_rows(logic [191:0] d);
    int pr[4][4] = '{'{1, 2, 3, 1}, '{3, 2, 0, 2}, '{3, 0, 1, 3}, '{1, 0, 2, 0}};
    longint n[4][3];
    longint e1[3], e2[3], e3[3], u[3], v[3], g[3];
    longint det, mag, s;
    logic [15:0] b[3];
    row_t r;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 3; j++) n[i][j] = crd(d, i*3 + j);
    for (int j = 0; j < 3; j++) begin
      e1[j] = n[1][j] - n[0][j];
      e2[j] = n[2][j] - n[0][j];
      e3[j] = n[3][j] - n[0][j];
      s = n[0][j] + n[1][j] + n[2][j] + n[3][j];
      b[j] = 16'(s / 4);
    end
    det = e1[0] * (e2[1]*e3[2] - e2[2]*e3[1]) + e1[1] * (e2[2]*e3[0] - e2[0]*e3[2])
        + e1[2] * (e2[0]*e3[1] - e2[1]*e3[0]);
    mag = det < 0 ? -det : det;
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 3; j++) begin
        u[j] = n[pr[k][0]][j] - n[pr[k][1]][j];
        v[j] = n[pr[k][2]][j] - n[pr[k][3]][j];
      end
      g[0] = u[1]*v[2] - u[2]*v[1];
      g[1] = u[2]*v[0] - u[0]*v[2];
      g[2] = u[0]*v[1] - u[1]*v[0];
      r.vidx = 2'(k);
      r.gx = mag == 0 ? '0 : scaled_quot(g[0], mag);
      r.gy = mag == 0 ? '0 : scaled_quot(g[1], mag);
      r.gz = mag == 0 ? '0 : scaled_quot(g[2], mag);
      r.vol = 51'(mag / 6);
      r.bx = b[0];
      r.by = b[1];
      r.bz = b[2];
      r.degen = mag == 0;
      r.last = k == 3;
      row_q.push_back(r);
    end
  endtask

  function automatic logic [191:0] pack_tet(longint c[12]);
    logic [191:0] d;
    for (int i = 0; i < 12; i++) d[i*16 +: 16] = 16'(c[i]);
    return d;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_rows(in_tdata);
      end
      if ((in_tvalid && !in_tready)) begin
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (tet_q.size() > 0) begin
        in_tdata <= tet_q.pop_front();
        in_tvalid <= 1'b1;
        in_gap <= gap_len();
      end else begin
        in_tvalid <= 1'b0;
        stim_done <= !in_tvalid || in_tready;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    row_t r;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        rows_seen <= rows_seen + 1;
        if (row_q.size() == 0) begin
          $error("unexpected output word");
          errors++;
        end else begin
          r = row_q.pop_front();
          if (out_tuser[1:0] !== r.vidx) begin
            $error("vertex_index exp %0d got %0d", r.vidx, out_tuser[1:0]); errors++;
          end
          if (out_tdata[47:0] !== r.gx) begin
            $error("grad_x exp %h got %h", r.gx, out_tdata[47:0]); errors++;
          end
          if (out_tdata[95:48] !== r.gy) begin
            $error("grad_y exp %h got %h", r.gy, out_tdata[95:48]); errors++;
          end
          if (out_tdata[143:96] !== r.gz) begin
            $error("grad_z exp %h got %h", r.gz, out_tdata[143:96]); errors++;
          end
          if (out_tdata[194:144] !== r.vol) begin
            $error("volume exp %h got %h", r.vol, out_tdata[194:144]); errors++;
          end
          if (out_tdata[210:195] !== r.bx) begin
            $error("bary_x exp %h got %h", r.bx, out_tdata[210:195]); errors++;
          end
          if (out_tdata[226:211] !== r.by) begin
            $error("bary_y exp %h got %h", r.by, out_tdata[226:211]); errors++;
          end
          if (out_tdata[242:227] !== r.bz) begin
            $error("bary_z exp %h got %h", r.bz, out_tdata[242:227]); errors++;
          end
          if (out_tuser[2] !== r.degen) begin
            $error("degenerate exp %b got %b", r.degen, out_tuser[2]); errors++;
          end
          if (out_tlast !== r.last) begin
            $error("last_row exp %b got %b", r.last, out_tlast); errors++;
          end
        end
      end
      // long hold-off once, early on, to back up the queue
      if (rows_seen == 8 && hold_off == 0) begin
        hold_off <= 2000;
        out_tready <= 1'b0;
      end else if (hold_off > 1) begin
        hold_off <= hold_off - 1;
        out_tready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        hold_off <= (hold_off == 1) ? -1 : hold_off;
        out_tready <= 1'b0;
      end else begin
        hold_off <= (hold_off == 1) ? -1 : hold_off;
        out_tready <= 1'b1;
        out_gap <= (!out_tready) ? 0 : gap_len();
      end
    end
  end

  initial begin
    longint c[12];
    int lim[5] = '{-32768, 32767, 0, -1, 1};
    for (int i = 0; i < 12; i++) c[i] = 0;
    tet_q.push_back(pack_tet(c));  // flat: all at origin
    c = '{0, 0, 0, 16384, 0, 0, 0, 16384, 0, 0, 0, 16384};
    tet_q.push_back(pack_tet(c));  // unit corner
    c = '{0, 0, 0, 16384, 0, 0, 0, 16384, 0, 0, 0, -16384};
    tet_q.push_back(pack_tet(c));  // negative orientation
    c = '{0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1};
    tet_q.push_back(pack_tet(c));  // tiny volume, large gradients
    c = '{0, 0, 0, 2, 0, 0, 0, 3, 0, 0, 0, 1};
    tet_q.push_back(pack_tet(c));  // |D| = 6
    c = '{-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768,
          -32768, -32768, 32767};
    tet_q.push_back(pack_tet(c));  // largest volume
    c = '{32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768, 32767,
          32767, 32767, -32768};
    tet_q.push_back(pack_tet(c));
    c = '{0, 0, 0, 100, 0, 0, 200, 0, 0, 300, 5, 7};
    tet_q.push_back(pack_tet(c));  // collinear-ish, flat
    for (int i = 0; i < 12; i++) c[i] = -32768;
    tet_q.push_back(pack_tet(c));  // flat at the corner
    for (int t = 0; t < 8; t++) begin
      for (int i = 0; i < 12; i++) c[i] = lim[$urandom_range(0, 4)];
      tet_q.push_back(pack_tet(c));
    end
    for (int t = 0; t < 200; t++) begin
      case ($urandom_range(0, 3))
        0: for (int i = 0; i < 12; i++) c[i] = $signed(16'($urandom()));
        1: begin
          for (int i = 0; i < 3; i++) c[i] = $signed(16'($urandom()));
          for (int i = 3; i < 12; i++) c[i] = c[i % 3] + $signed(4'($urandom()));
        end
        2: begin
          // three points on a line with a fourth: always flat
          for (int i = 0; i < 6; i++) c[i] = $urandom_range(0, 2000) - 1000;
          for (int i = 6; i < 9; i++) c[i] = 2*c[i-3] - c[i-6];
          for (int i = 9; i < 12; i++) c[i] = $urandom_range(0, 1) ? c[i-3] : -c[i-9];
        end
        default: for (int i = 0; i < 12; i++) c[i] = lim[$urandom_range(0, 4)];
      endcase
      tet_q.push_back(pack_tet(c));
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done && row_q.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(12ns * 1000000);
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
`default_nettype wire
